FILE: hw/rtl/brbd_pkg.sv
// Shared types, opcodes, status codes and the popcount function for the bucket directory.
package brbd_pkg;

    localparam int DEF_WORD_BITS   = 64;
    localparam int DEF_MAX_BUCKETS = 65536;
    localparam int CFG_W           = 17;
    localparam int CNT_W           = 17;
    localparam logic [CNT_W-1:0] CNT_SAT  = 17'h1FFFF;
    localparam logic [31:0]      CONF_SAT = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_INSERT = 2'd1,
        OP_BUILD  = 2'd2,
        OP_LOOKUP = 2'd3
    } op_t;

    localparam logic [1:0] STAT_FOUND  = 2'd0;
    localparam logic [1:0] STAT_EMPTY  = 2'd1;
    localparam logic [1:0] STAT_BEYOND = 2'd2;

    typedef struct packed {
        op_t         opcode;
        logic [31:0] hash_index;
    } dir_in_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [15:0]      slot;
        logic             collided;
        logic [CNT_W-1:0] filled_buckets;
        logic [31:0]      conflicts;
    } dir_out_t;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_DIV_POS,
        S_READ,
        S_EXEC,
        S_BLD_RD,
        S_BLD_ACC,
        S_DONE
    } state_t;

    // adder tree popcount, six levels
    function automatic logic [6:0] pop64(input logic [63:0] w);
        logic [6:0] t [64];
        for (int i = 0; i < 64; i++)
        begin
            t[i] = 7'(w[i]);
        end
        for (int lvl = 0; lvl < 6; lvl++)
        begin
            for (int i = 0; i < (32 >> lvl); i++)
            begin
                t[i] = t[2*i] + t[2*i+1];
            end
        end
        return t[0];
    endfunction

endpackage

FILE: hw/rtl/brbd_ram.sv
// Generic single-port RAM with registered read.
module brbd_ram
    import brbd_pkg::*;
#(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1025
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/brbd_div.sv
// Shared restoring divider, one quotient bit per cycle.
module brbd_div
    import brbd_pkg::*;
#(
    parameter int DIV_W = 17
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [31:0]      dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] rem
);

    logic [31:0]      q_reg, q_next;
    logic [DIV_W-1:0] r_reg, r_next;
    logic [DIV_W-1:0] d_reg, d_next;
    logic [4:0]       cnt_reg, cnt_next;
    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [DIV_W:0]   trial;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        trial     = {r_reg, q_reg[31]};
        if (start)
        begin
            q_next   = dividend;
            r_next   = '0;
            d_next   = divisor;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_next = DIV_W'(trial - {1'b0, d_reg});
                q_next = {q_reg[30:0], 1'b1};
            end
            else
            begin
                r_next = trial[DIV_W-1:0];
                q_next = {q_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done = done_reg;
    assign rem  = r_reg;

endmodule

FILE: hw/rtl/bitmap_rank_bucket_directory_top.sv
// Top level of the bitmap rank bucket directory: sequencer, counters and storage.
//
// Usage
//   in channel  : one transfer carries an opcode and a 32-bit hash.
//   out channel : one result transfer per input transfer, in order.
//   cfg channel : writes bucket_count; always ready, write only while idle.
// Operation (one item in flight; in_ready is high only when idle)
//   insert/lookup : one divide (hash mod buckets) on the shared
//                   divider, word and offset split off by shift and mask
//                   (WORD_BITS must be a power of two; the block does not
//                   check it), then a word read and, for insert, an update.
//   build         : a read step and an accumulate step per bitmap word,
//                   walking every word on the shared RAM address.
//   clear         : one word per cycle over all NWORDS words.
// Reset
//   Counters clear at once; a sweep then zeroes all NWORDS words of both
//   RAMs, with in_ready low. No result comes from this sweep.
// Stalls
//   A finished result sits in the output register; the next item may be
//   accepted meanwhile, and its result waits in the sequencer until the
//   output register has been taken.
module bitmap_rank_bucket_directory_top
    import brbd_pkg::*;
#(
    parameter int WORD_BITS   = DEF_WORD_BITS,
    parameter int MAX_BUCKETS = DEF_MAX_BUCKETS
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  dir_in_t          in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output dir_out_t         out_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int NWORDS = MAX_BUCKETS / WORD_BITS + 1;
    localparam int AW     = $clog2(NWORDS);
    localparam int OFF_W  = $clog2(WORD_BITS);
    localparam int DIV_W  = $clog2(MAX_BUCKETS + 1);
    localparam logic [AW-1:0] LAST_WORD = AW'(NWORDS - 1);

    state_t             state_reg, state_next;
    logic [AW-1:0]      cnt_reg, cnt_next;
    op_t                op_reg, op_next;
    logic [AW-1:0]      widx_reg, widx_next;
    logic [OFF_W-1:0]   off_reg, off_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [31:0]        conf_reg, conf_next;
    logic [CNT_W-1:0]   total_reg, total_next;
    logic [1:0]         status_reg, status_next;
    logic [15:0]        slot_reg, slot_next;
    logic               coll_reg, coll_next;
    logic               sweep_op_reg, sweep_op_next;
    logic [CFG_W-1:0]   cfg_reg;
    logic               out_valid_reg;
    dir_out_t           out_data_reg;

    logic               in_fire;
    logic               out_free;

    // divider hookup
    logic               div_start;
    logic [31:0]        div_dividend;
    logic [DIV_W-1:0]   div_divisor;
    logic               div_done;
    logic [DIV_W-1:0]   div_rem;
    logic [31:0]        eff_count;

    // RAM hookup
    logic [AW-1:0]        ram_addr;
    logic                 occ_we, rank_we;
    logic [WORD_BITS-1:0] occ_wdata, occ_rdata;
    logic [CNT_W-1:0]     rank_wdata, rank_rdata;

    // word datapath
    logic [OFF_W-1:0]     bit_pos;
    logic [WORD_BITS-1:0] bit_mask;
    logic [WORD_BITS-1:0] above_mask;
    logic                 bit_hit;
    logic [6:0]           pop_above;
    logic [6:0]           pop_word;
    logic [CNT_W:0]       rank_pos;
    logic [CNT_W:0]       build_sum;

    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign cfg_ready = 1'b1;

    // bucket count zero acts as one, above the maximum it is clamped
    always_comb
    begin
        if (cfg_reg == '0)
        begin
            eff_count = 32'd1;
        end
        else if ({15'b0, cfg_reg} > 32'(MAX_BUCKETS))
        begin
            eff_count = 32'(MAX_BUCKETS);
        end
        else
        begin
            eff_count = {15'b0, cfg_reg};
        end
    end

    // offset 0 is the top bit of a word
    assign bit_pos    = OFF_W'(WORD_BITS - 1) - off_reg;
    assign bit_mask   = {{(WORD_BITS-1){1'b0}}, 1'b1} << bit_pos;
    assign above_mask = ~({WORD_BITS{1'b1}} >> off_reg);
    assign bit_hit    = |(occ_rdata & bit_mask);
    assign pop_above  = pop64(64'(occ_rdata & above_mask));
    assign pop_word   = pop64(64'(occ_rdata));
    assign rank_pos   = {1'b0, rank_rdata} + (CNT_W+1)'(pop_above);
    assign build_sum  = {1'b0, total_reg} + (CNT_W+1)'(pop_word);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLR:
            begin
                if (cnt_reg == LAST_WORD)
                begin
                    state_next = sweep_op_reg ? S_DONE : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (in_data.opcode)
                        OP_CLEAR:  state_next = S_CLR;
                        OP_BUILD:  state_next = S_BLD_RD;
                        OP_INSERT,
                        OP_LOOKUP: state_next = S_DIV_POS;
                    endcase
                end
            end
            S_DIV_POS:
            begin
                if (div_done)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:    state_next = S_EXEC;
            S_EXEC:    state_next = S_DONE;
            S_BLD_RD:  state_next = S_BLD_ACC;
            S_BLD_ACC:
            begin
                state_next = (cnt_reg == LAST_WORD) ? S_DONE : S_BLD_RD;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        in_ready     = 1'b0;
        div_start    = 1'b0;
        div_dividend = in_data.hash_index;
        div_divisor  = DIV_W'(eff_count);
        ram_addr     = widx_reg;
        occ_we       = 1'b0;
        rank_we      = 1'b0;
        occ_wdata    = occ_rdata | bit_mask;
        rank_wdata   = total_reg;
        unique case (state_reg)
            S_CLR:
            begin
                ram_addr   = cnt_reg;
                occ_we     = 1'b1;
                rank_we    = 1'b1;
                occ_wdata  = '0;
                rank_wdata = '0;
            end
            S_IDLE:
            begin
                in_ready  = 1'b1;
                div_start = in_fire && ((in_data.opcode == OP_INSERT) ||
                                        (in_data.opcode == OP_LOOKUP));
            end
            S_EXEC:
            begin
                occ_we = (op_reg == OP_INSERT) && !bit_hit;
            end
            S_BLD_RD:
            begin
                ram_addr = cnt_reg;
            end
            S_BLD_ACC:
            begin
                ram_addr = cnt_reg;
                rank_we  = 1'b1;
            end
            S_DIV_POS, S_READ, S_DONE:
            begin
                ram_addr = widx_reg;
            end
            default:
            begin
                ram_addr = widx_reg;
            end
        endcase
    end

    // datapath registers
    always_comb
    begin
        cnt_next      = cnt_reg;
        op_next       = op_reg;
        widx_next     = widx_reg;
        off_next      = off_reg;
        fill_next     = fill_reg;
        conf_next     = conf_reg;
        total_next    = total_reg;
        status_next   = status_reg;
        slot_next     = slot_reg;
        coll_next     = coll_reg;
        sweep_op_next = sweep_op_reg;
        unique case (state_reg)
            S_CLR:
            begin
                cnt_next = cnt_reg + AW'(1);
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    op_next     = in_data.opcode;
                    cnt_next    = '0;
                    total_next  = '0;
                    status_next = STAT_FOUND;
                    slot_next   = '0;
                    coll_next   = 1'b0;
                    if (in_data.opcode == OP_CLEAR)
                    begin
                        fill_next     = '0;
                        conf_next     = '0;
                        sweep_op_next = 1'b1;
                    end
                end
            end
            S_DIV_POS:
            begin
                // bucket splits into word and offset by shift and mask
                if (div_done)
                begin
                    widx_next = AW'(div_rem >> OFF_W);
                    off_next  = div_rem[OFF_W-1:0];
                end
            end
            S_EXEC:
            begin
                if (op_reg == OP_INSERT)
                begin
                    if (bit_hit)
                    begin
                        coll_next = 1'b1;
                        if (conf_reg != CONF_SAT)
                        begin
                            conf_next = conf_reg + 32'd1;
                        end
                    end
                    else if (fill_reg != CNT_SAT)
                    begin
                        fill_next = fill_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    if (!bit_hit)
                    begin
                        status_next = STAT_EMPTY;
                    end
                    else if (rank_pos >= {1'b0, fill_reg})
                    begin
                        status_next = STAT_BEYOND;
                    end
                    else
                    begin
                        slot_next = rank_pos[15:0];
                    end
                end
            end
            S_BLD_ACC:
            begin
                cnt_next   = cnt_reg + AW'(1);
                total_next = (build_sum > {1'b0, CNT_SAT}) ? CNT_SAT
                                                           : build_sum[CNT_W-1:0];
            end
            S_READ, S_BLD_RD, S_DONE:
            begin
                cnt_next = cnt_reg;
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            cnt_reg       <= '0;
            fill_reg      <= '0;
            conf_reg      <= '0;
            sweep_op_reg  <= 1'b0;
            cfg_reg       <= CFG_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            fill_reg     <= fill_next;
            conf_reg     <= conf_next;
            sweep_op_reg <= (state_reg == S_CLR && cnt_reg == LAST_WORD) ? 1'b0
                                                                          : sweep_op_next;
            if (cfg_valid && cfg_ready)
            begin
                cfg_reg <= cfg_data;
            end
            if (state_reg == S_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        widx_reg   <= widx_next;
        off_reg    <= off_next;
        total_reg  <= total_next;
        status_reg <= status_next;
        slot_reg   <= slot_next;
        coll_reg   <= coll_next;
        if (state_reg == S_DONE && out_free)
        begin
            out_data_reg.status         <= status_reg;
            out_data_reg.slot           <= slot_reg;
            out_data_reg.collided       <= coll_reg;
            out_data_reg.filled_buckets <= fill_reg;
            out_data_reg.conflicts      <= conf_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    brbd_div #(
        .DIV_W(DIV_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .rem      (div_rem)
    );

    brbd_ram #(
        .WIDTH(WORD_BITS),
        .DEPTH(NWORDS)
    ) u_occ_ram (
        .clk   (clk),
        .we    (occ_we),
        .addr  (ram_addr),
        .wdata (occ_wdata),
        .rdata (occ_rdata)
    );

    brbd_ram #(
        .WIDTH(CNT_W),
        .DEPTH(NWORDS)
    ) u_rank_ram (
        .clk   (clk),
        .we    (rank_we),
        .addr  (ram_addr),
        .wdata (rank_wdata),
        .rdata (rank_rdata)
    );

    // divider only finishes while the sequencer waits on it
    a_div_done_ctx: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV_POS))
        else $error("divider finished outside a divide step");

    // fill count only falls on a clear transfer
    a_fill_mono: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg < $past(fill_reg)) |-> $past(in_fire && in_data.opcode == OP_CLEAR))
        else $error("fill count fell without a clear");

    // a failed lookup never reports a slot
    a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.status != STAT_FOUND) |-> (out_data.slot == 16'd0))
        else $error("slot set on a failed lookup");

endmodule
